// ----- rtl/core/fba_pkg.sv -----
// Shared constants, codes and types of the frame bitmap allocator.
`timescale 1ns / 1ps

package fba_pkg;

  localparam int unsigned BITMAP_WORDS  = 1024;
  localparam int unsigned BITS_PER_WORD = 32;

  localparam int unsigned WORD_AW = $clog2(BITMAP_WORDS);   // bitmap word address
  localparam int unsigned BIT_W   = $clog2(BITS_PER_WORD);  // bit within a word
  localparam int unsigned FRAME_W = 15;                     // frame number field
  localparam int unsigned LIMIT_W = 11;                     // words_in_use register
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned HWORD_W = FRAME_W - BIT_W;        // word index taken from a frame

  localparam logic [LIMIT_W-1:0] WORDS_IN_USE_RST = LIMIT_W'(1024);

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_MARK_USED = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK_FREE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TEST      = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC     = 2'd3;

  // Register index
  localparam logic REG_WORDS_IN_USE = 1'b0;

  typedef struct packed {
    logic                     we;
    logic [WORD_AW-1:0]       waddr;
    logic [BITS_PER_WORD-1:0] wdata;
    logic                     re;
    logic [WORD_AW-1:0]       raddr;
  } ram_req_t;

  typedef struct packed {
    logic               done;
    logic               ok;
    logic [FRAME_W-1:0] frame;
    logic               was_used;
  } result_t;

endpackage

// ----- rtl/core/fba_ram.sv -----
// Bitmap store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module fba_ram (
  input  logic                              clk_i,
  input  fba_pkg::ram_req_t                 req_i,
  output logic [fba_pkg::BITS_PER_WORD-1:0] rdata_o
);

  logic [fba_pkg::BITS_PER_WORD-1:0] mem [fba_pkg::BITMAP_WORDS];
  logic [fba_pkg::BITS_PER_WORD-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/fba_lzb.sv -----
// Lowest clear bit finder over one bitmap word.
`timescale 1ns / 1ps

module fba_lzb (
  input  logic [fba_pkg::BITS_PER_WORD-1:0] word_i,
  output logic                              found_o,
  output logic [fba_pkg::BIT_W-1:0]         idx_o
);

  always_comb begin
    idx_o = '0;
    // walk downwards so the lowest clear bit wins
    for (int i = fba_pkg::BITS_PER_WORD - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        idx_o = fba_pkg::BIT_W'(i);
      end
    end
  end

  assign found_o = ~&word_i;

endmodule

// ----- rtl/core/fba_engine.sv -----
// Request sequencer: clearing pass, read-modify-write or test read, and allocate scan.
`timescale 1ns / 1ps

module fba_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [fba_pkg::FUNC_W-1:0]          func_i,
  input  logic [fba_pkg::FRAME_W-1:0]         frame_number_i,
  input  logic [fba_pkg::FRAME_W-1:0]         hint_frame_i,
  input  logic [fba_pkg::LIMIT_W-1:0]         words_in_use_i,
  output logic                                busy_o,
  output fba_pkg::ram_req_t                   ram_req_o,
  input  logic [fba_pkg::BITS_PER_WORD-1:0]   ram_rdata_i,
  output fba_pkg::result_t                    res_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RD    = 2'd2;
  localparam logic [1:0] ST_SCAN  = 2'd3;

  localparam int unsigned AW = fba_pkg::WORD_AW;
  localparam int unsigned LW = fba_pkg::LIMIT_W;
  localparam int unsigned DW = fba_pkg::BITS_PER_WORD;
  localparam int unsigned BW = fba_pkg::BIT_W;

  logic [1:0]                  state_q, state_d;
  logic [AW-1:0]               clr_q, clr_d;
  logic [fba_pkg::FUNC_W-1:0]  func_q, func_d;
  logic [AW-1:0]               word_q, word_d;
  logic [BW-1:0]               bit_q, bit_d;
  logic [LW-1:0]               iss_q, iss_d;        // next word to read
  logic [LW-1:0]               end_q, end_d;        // end of the current pass
  logic                        wrap_q, wrap_d;      // wrap pass still pending
  logic [LW-1:0]               wrap_end_q, wrap_end_d;
  logic                        dv_q, dv_d;          // read data arrives this cycle
  logic [AW-1:0]               dw_q, dw_d;          // word the read data belongs to
  fba_pkg::result_t            res_q, res_d;

  logic [LW-1:0]               limit;
  logic [LW-1:0]               hw;
  logic [DW-1:0]               mask;
  logic                        lzb_found;
  logic [BW-1:0]               lzb_idx;

  fba_lzb u_lzb (
    .word_i  (ram_rdata_i),
    .found_o (lzb_found),
    .idx_o   (lzb_idx)
  );

  assign limit = (words_in_use_i >= LW'(fba_pkg::BITMAP_WORDS)) ?
                 LW'(fba_pkg::BITMAP_WORDS) : words_in_use_i;
  assign hw    = LW'(hint_frame_i[fba_pkg::FRAME_W-1:BW]);
  assign mask  = DW'(1) << bit_q;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    func_d     = func_q;
    word_d     = word_q;
    bit_d      = bit_q;
    iss_d      = iss_q;
    end_d      = end_q;
    wrap_d     = wrap_q;
    wrap_end_d = wrap_end_q;
    dv_d       = 1'b0;
    dw_d       = dw_q;
    res_d      = res_q;
    res_d.done = 1'b0;
    ram_req_o  = '0;

    case (state_q)
      ST_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = clr_q;
        ram_req_o.wdata = '1;
        clr_d           = clr_q + AW'(1);
        if (clr_q == AW'(fba_pkg::BITMAP_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          func_d = func_i;
          word_d = AW'(frame_number_i[fba_pkg::FRAME_W-1:BW]);
          bit_d  = frame_number_i[BW-1:0];
          if (func_i == fba_pkg::FUNC_ALLOC) begin
            iss_d      = hw;
            end_d      = limit;
            wrap_d     = (hw != '0);
            wrap_end_d = (hw < limit) ? hw : limit;
            state_d    = ST_SCAN;
          end else begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = AW'(frame_number_i[fba_pkg::FRAME_W-1:BW]);
            state_d         = ST_RD;
          end
        end
      end
      ST_RD: begin
        res_d.done     = 1'b1;
        res_d.ok       = 1'b1;
        res_d.frame    = '0;
        res_d.was_used = 1'b0;
        ram_req_o.waddr = word_q;
        if (func_q == fba_pkg::FUNC_MARK_USED) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = ram_rdata_i | mask;
        end else if (func_q == fba_pkg::FUNC_MARK_FREE) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = ram_rdata_i & ~mask;
        end else begin
          res_d.was_used = ram_rdata_i[bit_q];
        end
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (dv_q && lzb_found) begin
          // first word with room: claim its lowest clear bit
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = dw_q;
          ram_req_o.wdata = ram_rdata_i | (DW'(1) << lzb_idx);
          res_d.done      = 1'b1;
          res_d.ok        = 1'b1;
          res_d.frame     = fba_pkg::FRAME_W'({dw_q, lzb_idx});
          res_d.was_used  = 1'b0;
          state_d         = ST_IDLE;
        end else if (iss_q < end_q) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = iss_q[AW-1:0];
          iss_d           = iss_q + LW'(1);
          dv_d            = 1'b1;
          dw_d            = iss_q[AW-1:0];
        end else if (wrap_q) begin
          iss_d  = '0;
          end_d  = wrap_end_q;
          wrap_d = 1'b0;
        end else begin
          res_d.done     = 1'b1;
          res_d.ok       = 1'b0;
          res_d.frame    = '0;
          res_d.was_used = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      dv_q    <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      dv_q    <= dv_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q         <= func_d;
    word_q         <= word_d;
    bit_q          <= bit_d;
    iss_q          <= iss_d;
    end_q          <= end_d;
    wrap_q         <= wrap_d;
    wrap_end_q     <= wrap_end_d;
    dw_q           <= dw_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign res_o  = res_q;

endmodule

// ----- rtl/core/frame_bitmap_allocator.sv -----
// Top level of the frame bitmap allocator: register port, sequencer and bitmap store.
`timescale 1ns / 1ps

// Channel   | Handshake                          | Payload
// ----------+------------------------------------+-----------------------------------
// request   | start high while busy low          | func_i, frame_number_i, hint_frame_i
// result    | done_o high for one cycle          | ok_o, frame_out_o, was_used_o
// register  | psel & penable & pwrite (pready=1) | paddr, pwdata -> words_in_use
//
// Mark used and mark free: one read and one write of the bitmap word; test: one
// read only. The result strobe comes from the result register after the read state.
// Allocate: one bitmap read a cycle, except in the step that starts the wrap pass,
// pipelined with the check of the word read the cycle before.
// The single read port of the bitmap memory sets this pace.
// After reset a clearing pass writes all ones into the 1024 words with busy high;
// register writes are taken meanwhile.
// The result has no back-pressure: done_o is high for exactly one cycle; its fields hold until the next result.
module frame_bitmap_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request
  input  logic                               start,
  output logic                               busy,
  input  logic [fba_pkg::FUNC_W-1:0]         func_i,
  input  logic [fba_pkg::FRAME_W-1:0]        frame_number_i,
  input  logic [fba_pkg::FRAME_W-1:0]        hint_frame_i,
  // result
  output logic                               done_o,
  output logic                               ok_o,
  output logic [fba_pkg::FRAME_W-1:0]        frame_out_o,
  output logic                               was_used_o,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fba_pkg::PADDR_W-1:0]        paddr,
  input  logic [fba_pkg::PDATA_W-1:0]        pwdata,
  output logic [fba_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  logic [fba_pkg::LIMIT_W-1:0]       words_in_use_q;
  logic                              reg_sel;
  fba_pkg::ram_req_t                 ram_req;
  logic [fba_pkg::BITS_PER_WORD-1:0] ram_rdata;
  fba_pkg::result_t                  res;

  // one register; bit 2 of the byte address is its index
  assign reg_sel = (paddr[2] == fba_pkg::REG_WORDS_IN_USE);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_in_use_q <= fba_pkg::WORDS_IN_USE_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      words_in_use_q <= pwdata[fba_pkg::LIMIT_W-1:0];
    end
  end

  assign prdata = reg_sel ? fba_pkg::PDATA_W'(words_in_use_q) : '0;

  fba_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .func_i         (func_i),
    .frame_number_i (frame_number_i),
    .hint_frame_i   (hint_frame_i),
    .words_in_use_i (words_in_use_q),
    .busy_o         (busy),
    .ram_req_o      (ram_req),
    .ram_rdata_i    (ram_rdata),
    .res_o          (res)
  );

  fba_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign done_o      = res.done;
  assign ok_o        = res.ok;
  assign frame_out_o = res.frame;
  assign was_used_o  = res.was_used;

endmodule
